// ----- rtl/rala_pkg.sv -----
// Package for the remote access latency model: field widths, command and
// register codes, reset values and the sequencer state type.
// No dependencies.
package rala_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned SID_IN_W = 8;
  localparam int unsigned T_W      = 64;
  localparam int unsigned BW_W     = 40;
  localparam int unsigned RTT_W    = 32;
  localparam int unsigned SC_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;

  // product of bytes and ns per second stays below 2^62
  localparam int unsigned PROD_W    = 62;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned NS_BITS   = 30;
  localparam logic [NS_BITS-1:0] NS_PER_SEC   = 30'd1000000000;
  localparam logic [LEN_W-1:0]   ATOMIC_BYTES = 32'd8;
  localparam logic [CNT_W-1:0]   MUL_LAST_BIT = 6'(NS_BITS - 1);
  localparam logic [CNT_W-1:0]   DIV_LAST_BIT = 6'(PROD_W - 1);

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CAS   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FAA   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RTT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVERS   = 2'd2;

  localparam logic [BW_W-1:0]  RST_BANDWIDTH = 40'd12500000000;
  localparam logic [RTT_W-1:0] RST_BASE_RTT  = 32'd2000;
  localparam logic [SC_W-1:0]  RST_SERVERS   = 5'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_QUEUE,
    ST_BUSY,
    ST_DELAY,
    ST_WAIT1,
    ST_WAIT2,
    ST_RTT1,
    ST_RTT2,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/remote_access_latency_model_unit.sv -----
// Remote access latency model: transfer time, per-server queueing, batch
// waits, per-kind counts and round-trip total for each request.
// Depends on rala_pkg.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | cmd, length, server, time, batch marks
//   out_    | output    | out_valid / out_ready | ok, waits, server delay, count, rtt total
//   cfg_    | input     | cfg_valid / cfg_ready | register index, write data
//
// A request that goes ahead runs a bit-serial multiply over the 30 bits of
// 1e9, a restoring divide by the bandwidth giving 62 quotient bits (one
// quotient bit a cycle), 7 add-and-compare steps and the output load. The
// next request is taken only once that result is loaded. A refused request
// (bad server or abandoned batch) goes from idle straight to the output load.
// rst_n is synchronous; it clears the server busy valid bits, counters and
// batch state, and loads the register defaults. Register writes are taken
// only when idle with no request offered. A result held by a low out_ready
// stalls only the last step; the next request is taken meanwhile.
module remote_access_latency_model_unit #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rala_pkg::CMD_W-1:0]     in_cmd,
  input  logic [rala_pkg::LEN_W-1:0]     in_length_bytes,
  input  logic [rala_pkg::SID_IN_W-1:0]  in_server_id,
  input  logic [rala_pkg::T_W-1:0]       in_now_ns,
  input  logic                           in_in_batch,
  input  logic                           in_batch_first,
  input  logic                           in_batch_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ok,
  output logic [rala_pkg::T_W-1:0]       out_wait_before_ns,
  output logic [rala_pkg::T_W-1:0]       out_wait_after_ns,
  output logic [rala_pkg::T_W-1:0]       out_server_delay_ns,
  output logic [rala_pkg::T_W-1:0]       out_kind_count,
  output logic [rala_pkg::T_W-1:0]       out_total_rtt_ns,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rala_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rala_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rala_pkg::*;

  localparam int SID_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam logic [SID_IN_W:0] SRV_LIMIT = (SID_IN_W + 1)'(MAX_SERVERS);

  state_t state_r, state_nxt;

  logic [BW_W-1:0]  bw_r;
  logic [RTT_W-1:0] base_rtt_r;
  logic [SC_W-1:0]  srv_cnt_r;

  logic [CMD_W-1:0] cmd_r;
  logic [LEN_W-1:0] bytes_r;
  logic [SID_W-1:0] id_r;
  logic [T_W-1:0]   now_r;
  logic             batch_r, first_r, last_r, ok_r;

  logic [PROD_W-1:0] acc_r;
  logic [BW_W:0]     rem_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [T_W-1:0] busy_mem [MAX_SERVERS];
  logic [T_W-1:0] busy_rd_r;
  logic [MAX_SERVERS-1:0] busy_vld_r;

  logic [T_W-1:0] queue_r, start_r, sd_r, before_r, after_r, inc_r;
  logic [T_W-1:0] kind_cnt_r [4];
  logic [T_W-1:0] kind_val_r, rtt_tot_r, batch_max_r;
  logic           batch_fail_r;

  logic           out_valid_r, out_valid_nxt;
  logic           out_ok_r;
  logic [T_W-1:0] out_before_r, out_after_r, out_sd_r, out_kind_r, out_rtt_r;

  logic           accept, load_out, id_good, item_ok;
  logic [T_W-1:0] one_way, trans, busy_val;
  logic [BW_W-1:0] bw_eff;
  logic [BW_W:0]   rem_sh;
  logic [BW_W+1:0] rem_diff;
  logic [T_W:0]    busy_diff;

  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign id_good  = ({1'b0, in_server_id} < SRV_LIMIT) &&
                    (in_server_id < {3'b000, srv_cnt_r});
  // a batch member without a first mark inherits a failed batch
  assign item_ok  = id_good && !(in_in_batch && !in_batch_first && batch_fail_r);

  assign one_way  = {33'd0, base_rtt_r[RTT_W-1:1]};
  assign trans    = {2'b00, acc_r};
  assign bw_eff   = (bw_r == '0) ? BW_W'(1) : bw_r;
  assign busy_val = busy_vld_r[id_r] ? busy_rd_r : '0;

  assign rem_sh    = {rem_r[BW_W-1:0], acc_r[PROD_W-1]};
  assign rem_diff  = {1'b0, rem_sh} - {2'b00, bw_eff};
  assign busy_diff = {1'b0, busy_val} - {1'b0, now_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = item_ok ? ST_MUL : ST_OUT;
      ST_MUL:   if (cnt_r == '0) state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == '0) state_nxt = ST_QUEUE;
      ST_QUEUE: state_nxt = ST_BUSY;
      ST_BUSY:  state_nxt = ST_DELAY;
      ST_DELAY: state_nxt = ST_WAIT1;
      ST_WAIT1: state_nxt = ST_WAIT2;
      ST_WAIT2: state_nxt = ST_RTT1;
      ST_RTT1:  state_nxt = ST_RTT2;
      ST_RTT2:  state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready      = 1'b0;
    cfg_ready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready  = rst_n;
        // a register write never meets a request at the same edge
        cfg_ready = rst_n && !in_valid;
      end
      ST_OUT:  if (load_out) out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      bw_r         <= RST_BANDWIDTH;
      base_rtt_r   <= RST_BASE_RTT;
      srv_cnt_r    <= RST_SERVERS;
      busy_vld_r   <= '0;
      kind_cnt_r   <= '{default: '0};
      rtt_tot_r    <= '0;
      batch_max_r  <= '0;
      batch_fail_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BANDWIDTH: bw_r       <= cfg_data[BW_W-1:0];
          CFG_BASE_RTT:  base_rtt_r <= cfg_data[RTT_W-1:0];
          CFG_SERVERS:   srv_cnt_r  <= cfg_data[SC_W-1:0];
          default: ;
        endcase
      end

      if (accept && in_in_batch) begin
        if (!item_ok) begin
          batch_fail_r <= !in_batch_last;
          if (in_batch_first || in_batch_last) batch_max_r <= '0;
        end else if (in_batch_first) begin
          batch_fail_r <= 1'b0;
          batch_max_r  <= '0;
        end
      end

      case (state_r)
        ST_BUSY: begin
          busy_vld_r[id_r]  <= 1'b1;
          kind_cnt_r[cmd_r] <= kind_cnt_r[cmd_r] + T_W'(1);
        end
        ST_WAIT1: if (batch_r && (sd_r > batch_max_r)) batch_max_r <= sd_r;
        ST_WAIT2: if (batch_r && last_r) batch_max_r <= '0;
        ST_RTT2:  rtt_tot_r <= rtt_tot_r + inc_r;
        default: ;
      endcase
    end
  end

  // busy-until store: entries read as zero until their valid bit is set
  always_ff @(posedge clk) begin
    busy_rd_r <= busy_mem[id_r];
    if (state_r == ST_BUSY) busy_mem[id_r] <= start_r + trans;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      bytes_r <= (in_cmd == CMD_READ || in_cmd == CMD_WRITE) ? in_length_bytes
                                                             : ATOMIC_BYTES;
      id_r    <= in_server_id[SID_W-1:0];
      now_r   <= in_now_ns;
      batch_r <= in_in_batch;
      first_r <= in_batch_first;
      last_r  <= in_batch_last;
      ok_r    <= item_ok;
      acc_r   <= '0;
      rem_r   <= '0;
      cnt_r   <= MUL_LAST_BIT;
    end

    case (state_r)
      ST_MUL: begin
        // shift-add over the bits of 1e9, most significant first
        acc_r <= {acc_r[PROD_W-2:0], 1'b0} +
                 (NS_PER_SEC[cnt_r[4:0]] ? {30'd0, bytes_r} : '0);
        cnt_r <= (cnt_r == '0) ? DIV_LAST_BIT : cnt_r - CNT_W'(1);
      end
      ST_DIV: begin
        // restoring divide; quotient bits replace the dividend in acc_r
        rem_r <= rem_diff[BW_W+1] ? rem_sh : rem_diff[BW_W:0];
        acc_r <= {acc_r[PROD_W-2:0], !rem_diff[BW_W+1]};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      ST_QUEUE: begin
        queue_r <= busy_diff[T_W] ? '0 : busy_diff[T_W-1:0];
        start_r <= busy_diff[T_W] ? now_r : busy_val;
      end
      ST_BUSY:  kind_val_r <= kind_cnt_r[cmd_r] + T_W'(1);
      ST_DELAY: sd_r <= queue_r + trans;
      ST_WAIT1: begin
        if (batch_r) before_r <= first_r ? one_way : '0;
        else         before_r <= one_way + sd_r;
      end
      ST_WAIT2: begin
        if (batch_r)
          after_r <= last_r ? (((sd_r > batch_max_r) ? sd_r : batch_max_r) + one_way)
                            : '0;
        else
          after_r <= one_way + ((cmd_r == CMD_READ) ? trans : '0);
      end
      ST_RTT1: inc_r <= batch_r ? ({one_way[T_W-2:0], 1'b0} + sd_r) : (before_r + after_r);
      default: ;
    endcase

    if (load_out) begin
      out_ok_r     <= ok_r;
      out_before_r <= ok_r ? before_r   : '0;
      out_after_r  <= ok_r ? after_r    : '0;
      out_sd_r     <= ok_r ? sd_r       : '0;
      out_kind_r   <= ok_r ? kind_val_r : '0;
      out_rtt_r    <= ok_r ? rtt_tot_r  : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_wait_before_ns  = out_before_r;
  assign out_wait_after_ns   = out_after_r;
  assign out_server_delay_ns = out_sd_r;
  assign out_kind_count      = out_kind_r;
  assign out_total_rtt_ns    = out_rtt_r;

endmodule
